// ----- sv/dhkt_pkg.sv -----
// Shared types, constants and the probe step table of the double-hash key table.
`default_nettype none

package dhkt_pkg;

  localparam int INDEX_BITS_DEF = 12;
  localparam int PROBE_SHIFT    = 20;
  localparam int KEY_W          = 64;
  localparam int ID_W           = 21;
  localparam int PAY_W          = 32;
  localparam int STATUS_W       = 3;
  localparam int SLOT_W         = 12;
  localparam int PCNT_W         = 13;
  localparam int PCNT_MAX       = 8191;
  localparam int STEP_W         = 14;
  localparam int STEP_SEL_W     = 4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_FULL     = 3'd4,
    ST_ZERO_KEY = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_RESP
  } state_e;

  // one table entry as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
  } slot_t;

  // one result word
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  payload;
    logic [PCNT_W-1:0] probes;
  } rsp_t;

  // odd prime probe steps
  function automatic logic [STEP_W-1:0] step_prime(input logic [STEP_SEL_W-1:0] sel);
    logic [STEP_W-1:0] p;
    case (sel)
      4'd0:    p = 14'd5;
      4'd1:    p = 14'd11;
      4'd2:    p = 14'd37;
      4'd3:    p = 14'd103;
      4'd4:    p = 14'd293;
      4'd5:    p = 14'd991;
      4'd6:    p = 14'd2903;
      4'd7:    p = 14'd9931;
      4'd8:    p = 14'd7;
      4'd9:    p = 14'd19;
      4'd10:   p = 14'd73;
      4'd11:   p = 14'd10009;
      4'd12:   p = 14'd11149;
      4'd13:   p = 14'd12553;
      4'd14:   p = 14'd6229;
      4'd15:   p = 14'd10181;
      default: p = 14'd5;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dhkt_if.sv -----
// Request and response channel interfaces of the double-hash key table.
`default_nettype none

interface dhkt_req_if import dhkt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] key;
  logic [ID_W-1:0]  pattern_id;
  logic [PAY_W-1:0] payload;

  modport source (output valid, operation, key, pattern_id, payload, input ready);
  modport sink   (input valid, operation, key, pattern_id, payload, output ready);
endinterface

interface dhkt_rsp_if import dhkt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [ID_W-1:0]     found_id;
  logic [PAY_W-1:0]    found_payload;
  logic [PCNT_W-1:0]   probe_count;

  modport source (output valid, status, slot_index, found_id, found_payload, probe_count,
                  input ready);
  modport sink   (input valid, status, slot_index, found_id, found_payload, probe_count,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/double_hash_key_table_top.sv -----
// Top level of the double-hash key table: probe sequencer around one slot memory.
`default_nettype none

// Open-addressing table of 2^INDEX_BITS slots, each a 64-bit key with a 21-bit
// pattern id and a 32-bit payload word; key zero marks an empty slot. A request
// word does a lookup (hit with stored data, or miss) or an insert (first empty
// slot in the probe sequence, or "already present" with the entry untouched).
// The probe starts at key[20 +: INDEX_BITS] and steps by an odd prime picked
// by the next four key bits, wrapping modulo the table size. After table-size
// steps without a match or an empty slot the request ends as "table full".
// A zero key is rejected without touching the table.
// Timing: after reset the block sweeps every slot of the memory to zero and
// holds req ready low meanwhile. Then a request passes the read state, one
// compare state per slot probed (one slot per cycle through the single read
// port with its registered read data) and the response state before the
// response is loaded; a zero key goes straight to the response state. Requests
// are handled one at a time; a finished response sits in the output register,
// so the next request is accepted while it waits to be taken.
module double_hash_key_table_top
  import dhkt_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dhkt_req_if.sink   req_i,
  dhkt_rsp_if.source rsp_o
);

  localparam int TABLE_SIZE = 1 << INDEX_BITS;
  localparam int CNT_W      = INDEX_BITS + 1;
  localparam int SAT_W      = CNT_W + PCNT_W;

  // --- state ---------------------------------------------------------------
  state_e                state_q, state_d;
  logic [INDEX_BITS-1:0] clr_q;      // clearing sweep address
  logic                  op_q;
  logic [KEY_W-1:0]      key_q;
  logic [ID_W-1:0]       id_q;
  logic [PAY_W-1:0]      pay_q;
  logic [INDEX_BITS-1:0] h_q;        // current probe slot
  logic [INDEX_BITS-1:0] step_q;     // step, already reduced mod table size
  logic [CNT_W-1:0]      cnt_q;      // steps taken so far
  rsp_t                  res_q, res_d;
  logic                  res_ld;
  rsp_t                  out_q;
  logic                  out_valid_q;

  // --- memory port ---------------------------------------------------------
  logic                  mem_we, mem_re;
  logic [INDEX_BITS-1:0] mem_waddr, mem_raddr;
  slot_t                 mem_wdata, mem_rdata;

  // --- probe datapath ------------------------------------------------------
  logic                  req_acc;
  logic                  out_free;
  logic                  hit, empty, full, finish;
  logic [INDEX_BITS-1:0] h_next;
  logic [CNT_W-1:0]      cnt_next;

  function automatic logic [PCNT_W-1:0] sat_probes(input logic [CNT_W-1:0] c);
    logic [PCNT_W-1:0] r;
    if (SAT_W'(c) > SAT_W'(PCNT_MAX)) begin
      r = PCNT_W'(PCNT_MAX);
    end else begin
      r = PCNT_W'(c);
    end
    return r;
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // key_q is never zero while probing, so hit and empty exclude each other
  assign hit      = (mem_rdata.key == key_q);
  assign empty    = (mem_rdata.key == '0);
  assign h_next   = h_q + step_q;
  assign cnt_next = cnt_q + CNT_W'(1);
  assign full     = (cnt_next == CNT_W'(TABLE_SIZE));
  assign finish   = hit || empty || full;

  // --- next state ----------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_acc) begin
          state_d = (req_i.key == '0) ? S_RESP : S_READ;
        end
      end
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (finish) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --- memory control and result forming -----------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = h_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = h_q;
    res_ld    = 1'b0;
    res_d     = '0;
    res_d.status = ST_ZERO_KEY;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      S_IDLE: begin
        // zero key: result is all zero apart from the status
        res_ld = req_acc && (req_i.key == '0);
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      S_CHECK: begin
        res_ld = finish;
        if (!finish) begin
          // next slot read overlaps this compare
          mem_re    = 1'b1;
          mem_raddr = h_next;
        end
        res_d.slot   = SLOT_W'(h_q);
        res_d.probes = sat_probes(cnt_q);
        if (hit) begin
          res_d.status  = (op_q == OP_INSERT) ? ST_PRESENT : ST_HIT;
          res_d.id      = mem_rdata.id;
          res_d.payload = mem_rdata.payload;
        end else if (empty) begin
          res_d.status = (op_q == OP_INSERT) ? ST_INSERTED : ST_MISS;
          if (op_q == OP_INSERT) begin
            mem_we            = 1'b1;
            mem_wdata.key     = key_q;
            mem_wdata.id      = id_q;
            mem_wdata.payload = pay_q;
          end
        end else begin
          // every step is odd, so h_next is back at the start slot
          res_d.status = ST_FULL;
          res_d.slot   = SLOT_W'(h_next);
          res_d.probes = sat_probes(cnt_next);
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

  dhkt_mem #(
    .ADDR_W (INDEX_BITS),
    .DATA_W ($bits(slot_t))
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // --- control registers ---------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + INDEX_BITS'(1);
      if (req_acc) begin
        cnt_q <= '0;
      end else if (state_q == S_CHECK && !finish) begin
        cnt_q <= cnt_next;
      end
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --- payload registers ---------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q   <= req_i.operation;
      key_q  <= req_i.key;
      id_q   <= req_i.pattern_id;
      pay_q  <= req_i.payload;
      h_q    <= req_i.key[PROBE_SHIFT +: INDEX_BITS];
      step_q <= INDEX_BITS'(step_prime(req_i.key[PROBE_SHIFT + INDEX_BITS +: STEP_SEL_W]));
    end else if (state_q == S_CHECK && !finish) begin
      h_q <= h_next;
    end
    if (res_ld) res_q <= res_d;
    if (state_q == S_RESP && out_free) out_q <= res_q;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.slot_index    = out_q.slot;
  assign rsp_o.found_id      = out_q.id;
  assign rsp_o.found_payload = out_q.payload;
  assign rsp_o.probe_count   = out_q.probes;

  // --- assertions ----------------------------------------------------------
  // only the clearing sweep may write a zero key into the table
  a_no_zero_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != S_CLEAR) |-> (mem_wdata.key != '0))
    else $error("zero key written outside clearing");

  // table writes only come from the sweep or the compare step
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_CHECK))
    else $error("memory write in unexpected state");

  // probing never runs past one full cycle of the table
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_SIZE))
    else $error("probe counter past table size");

  // the response state follows the compare, or idle for a zero key, or holds
  a_resp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> ($past(state_q) == S_CHECK || $past(state_q) == S_IDLE
                             || $past(state_q) == S_RESP))
    else $error("response state entered out of order");

endmodule

`default_nettype wire

// ----- sv/dhkt_mem.sv -----
// Slot memory: one write port, one read port with registered read data.
`default_nettype none

module dhkt_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 117
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- bench/dhkt_checker.sv -----
// Checker for the double-hash key table: mirrors the slot memory and scores every reply word.
module dhkt_checker
  import dhkt_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  dhkt_req_if  req_i,
  dhkt_rsp_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int SLOTS = 1 << INDEX_BITS;

  // odd probe strides, entry 0 in the low bits
  localparam logic [16*STEP_W-1:0] STRIDES = {
    14'd10181, 14'd6229, 14'd12553, 14'd11149, 14'd10009, 14'd73, 14'd19, 14'd7,
    14'd9931,  14'd2903, 14'd991,   14'd293,   14'd103,   14'd37, 14'd11, 14'd5
  };

  logic [KEY_W-1:0] mirror_key [SLOTS];
  logic [ID_W-1:0]  mirror_id  [SLOTS];
  logic [PAY_W-1:0] mirror_pay [SLOTS];

  rsp_t table_replies [$];
  int   mismatches = 0;
  int   in_flight  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = in_flight;

  // walks the probe sequence on the mirror, writes it on insert, returns the reply word
  function automatic rsp_t probe_table(input logic op, input logic [KEY_W-1:0] k,
                                       input logic [ID_W-1:0] id, input logic [PAY_W-1:0] pay);
    rsp_t                  r;
    logic [INDEX_BITS-1:0] h;
    logic [STEP_W-1:0]     stride;
    int unsigned           hops;
    int                    sel;
    r = '0;
    if (k == '0) begin
      r.status = ST_ZERO_KEY;
      return r;
    end
    h      = k[PROBE_SHIFT +: INDEX_BITS];
    sel    = int'(k[PROBE_SHIFT+INDEX_BITS +: STEP_SEL_W]);
    stride = STRIDES[sel*STEP_W +: STEP_W];
    hops   = 0;
    while (1) begin
      if (mirror_key[h] == k) begin
        r.status  = (op == OP_INSERT) ? ST_PRESENT : ST_HIT;
        r.id      = mirror_id[h];
        r.payload = mirror_pay[h];
        break;
      end
      if (mirror_key[h] == '0) begin
        if (op == OP_INSERT) begin
          mirror_key[h] = k;
          mirror_id[h]  = id;
          mirror_pay[h] = pay;
          r.status      = ST_INSERTED;
        end else begin
          r.status = ST_MISS;
        end
        break;
      end
      h = h + INDEX_BITS'(stride);
      hops++;
      // odd stride: a full lap ends back at the start slot
      if (hops >= SLOTS) begin
        r.status = ST_FULL;
        break;
      end
    end
    r.slot   = SLOT_W'(h);
    r.probes = PCNT_W'((hops > PCNT_MAX) ? PCNT_MAX : hops);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        mirror_key[i] = '0;
        mirror_id[i]  = '0;
        mirror_pay[i] = '0;
      end
      table_replies.delete();
      in_flight <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (table_replies.size() == 0) begin
          $error("reply word with no request outstanding: status %0d slot %0d",
                 rsp_i.status, rsp_i.slot_index);
          mismatches++;
        end else begin
          want = table_replies.pop_front();
          compare_field("status", want.status, rsp_i.status);
          compare_field("slot_index", want.slot, rsp_i.slot_index);
          compare_field("found_id", want.id, rsp_i.found_id);
          compare_field("found_payload", want.payload, rsp_i.found_payload);
          compare_field("probe_count", want.probes, rsp_i.probe_count);
        end
      end
      if (req_i.valid && req_i.ready) begin
        table_replies.push_back(probe_table(req_i.operation, req_i.key,
                                            req_i.pattern_id, req_i.payload));
      end
      in_flight <= table_replies.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the double-hash key table: clock, reset, request traffic and verdict.
module tb;
  import dhkt_pkg::*;

  localparam int TABLE_SLOTS = 1 << INDEX_BITS_DEF;
  // Worst single word: a probe of a full table walks every slot;
  // the reset sweep is as long. Several times that with nothing moving = hang.
  localparam int STALL_LIMIT   = 40000;
  // settling after the drain covers a stray late reply word
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_WORDS   = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int req_idle_pct;
  int rsp_idle_pct;
  int quiet_cycles;
  int fail_count;
  int pending;

  // keys the table holds, tracked on the stimulus side to steer lookups
  bit               stored_keys [logic [KEY_W-1:0]];
  logic [KEY_W-1:0] known_keys [$];

  dhkt_req_if req ();
  dhkt_rsp_if rsp ();

  double_hash_key_table_top #(
    .INDEX_BITS(INDEX_BITS_DEF)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  dhkt_checker #(
    .INDEX_BITS(INDEX_BITS_DEF)
  ) chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // reply side back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  // hang guard: cycles in which neither channel moves a word
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // key layout at 12 index bits: stride select in [35:32], start slot in [31:20]
  function automatic logic [KEY_W-1:0] compose_key(input logic [27:0] upper,
                                                   input logic [3:0] sel,
                                                   input logic [11:0] slot,
                                                   input logic [19:0] low);
    return {upper, sel, slot, low};
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do begin
      k = {$urandom, $urandom};
    end while (k == '0 || stored_keys.exists(k));
    return k;
  endfunction

  // one request word; valid stays up across back-to-back words
  task automatic send_word(input logic op, input logic [KEY_W-1:0] k,
                           input logic [ID_W-1:0] id, input logic [PAY_W-1:0] pay);
    while ($urandom_range(99) < req_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.key        <= k;
    req.pattern_id <= id;
    req.payload    <= pay;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    // an insert of a new nonzero key lands as long as a slot is free
    if (op == OP_INSERT && k != '0 && !stored_keys.exists(k) &&
        stored_keys.num() < TABLE_SLOTS) begin
      stored_keys[k] = 1'b1;
      known_keys.push_back(k);
    end
  endtask

  task automatic random_word();
    logic [KEY_W-1:0] k;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] pay;
    int               pick;
    pick = $urandom_range(99);
    k    = {$urandom, $urandom};
    if (pick < 3) begin
      k = '0;
    end else if (pick < 38 && known_keys.size() != 0) begin
      // revisit a stored key: hits and already-present inserts
      k = known_keys[$urandom_range(known_keys.size() - 1)];
    end else if (pick < 80) begin
      // crowd keys onto a few start slots at both ends so chains grow long and wrap
      k[PROBE_SHIFT +: 12] = $urandom_range(1) ? 12'hFFF - 12'($urandom_range(3))
                                               : 12'($urandom_range(3));
      if ($urandom_range(1)) k[PROBE_SHIFT+12 +: STEP_SEL_W] = 4'($urandom_range(1));
    end
    id  = ID_W'($urandom);
    pay = $urandom;
    if ($urandom_range(9) == 0) id = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(9) == 0) pay = $urandom_range(1) ? '1 : '0;
    send_word(1'($urandom_range(1)), k, id, pay);
  endtask

  // hold requests back until every reply word has been taken
  task automatic drain_replies();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    req.valid      = 1'b0;
    req.operation  = OP_LOOKUP;
    req.key        = '0;
    req.pattern_id = '0;
    req.payload    = '0;
    rsp.ready      = 1'b0;
    req_idle_pct   = 7;
    rsp_idle_pct   = 64;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed words ---
    send_word(OP_LOOKUP, 64'd1, '0, '0);        // empty table: miss at slot 0
    send_word(OP_INSERT, '0, '1, '1);           // zero key rejected, table untouched
    send_word(OP_LOOKUP, '0, '0, '0);
    send_word(OP_INSERT, 64'd1, '0, '0);        // smallest key, zero data
    send_word(OP_LOOKUP, 64'd1, '1, '1);        // hit returns stored zeros
    send_word(OP_INSERT, 64'd1, '1, '1);        // already present, entry kept
    send_word(OP_INSERT, '1, '1, '1);           // all-ones: top slot, widest stride select
    send_word(OP_LOOKUP, '1, '0, '0);
    // same start slot and stride as all-ones: one step, wraps past the top
    send_word(OP_INSERT, compose_key(28'h7FFFFFF, 4'hF, 12'hFFF, 20'hFFFFF),
              21'h0AAAAA, 32'h5555_5555);
    send_word(OP_LOOKUP, compose_key(28'h7FFFFFF, 4'hF, 12'hFFF, 20'hFFFFF), '0, '0);
    send_word(OP_LOOKUP, compose_key(28'h0, 4'hF, 12'hFFF, 20'h0), '0, '0);
    // chain behind key 1 at slot 0 with stride 5
    for (int i = 1; i <= 3; i++) begin
      send_word(OP_INSERT, compose_key(28'(i), 4'h0, 12'h000, 20'(i)),
                ID_W'(i), PAY_W'(i));
    end
    send_word(OP_LOOKUP, compose_key(28'd3, 4'h0, 12'h000, 20'd3), '0, '0);
    send_word(OP_LOOKUP, compose_key(28'd9, 4'h0, 12'h000, 20'd0), '0, '0);
    // large stride, wider than the table
    send_word(OP_INSERT, compose_key(28'd5, 4'd11, 12'h000, 20'd7), '1, '0);

    // --- random traffic, sender mostly busy, receiver often stalled ---
    repeat (PHASE_WORDS) random_word();
    drain_replies();

    // --- roles swapped ---
    req_idle_pct = 64;
    rsp_idle_pct = 7;
    repeat (PHASE_WORDS) random_word();

    // --- no idling ---
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    repeat (60) random_word();

    // absent keys insert or miss, stored keys still resolve
    repeat (3) send_word(OP_INSERT, fresh_key(), ID_W'($urandom), $urandom);
    repeat (3) send_word(OP_LOOKUP, fresh_key(), '0, '0);
    repeat (4) begin
      send_word(OP_LOOKUP, known_keys[$urandom_range(known_keys.size() - 1)], '0, '0);
    end
    send_word(OP_INSERT, known_keys[0], '1, '1);
    send_word(OP_LOOKUP, '0, '0, '0);

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- double_hash_key_table_top.f -----
sv/dhkt_pkg.sv
sv/dhkt_if.sv
sv/dhkt_mem.sv
sv/double_hash_key_table_top.sv
bench/dhkt_checker.sv
bench/tb.sv
